FILE: rtl/lctlm_pkg.sv
// ----------------------------------------------------------------------------
// lctlm_pkg
// Shared types and codes of the Li Chao tree block: item payloads, the
// controller states, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lctlm_pkg;

	// Default number of offset bits of the covered x domain.
	localparam int DOMAIN_BITS_DEF = 10;

	// Configuration register indexes.
	localparam logic CFG_X_MIN = 1'b0;
	localparam logic CFG_MODE  = 1'b1;

	// Item operation codes.
	typedef enum logic [1:0] {
		OP_ADD_ALL = 2'd0,
		OP_ADD_SEG = 2'd1,
		OP_QUERY   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Evaluation point of a node: left end, mid point, right end, query x.
	typedef enum logic [1:0] {
		PT_LO  = 2'd0,
		PT_MID = 2'd1,
		PT_HI  = 2'd2,
		PT_QRY = 2'd3
	} pt_t;

	// Node index update.
	typedef enum logic [2:0] {
		IDX_HOLD    = 3'd0,
		IDX_ROOT    = 3'd1,
		IDX_LEFT    = 3'd2,
		IDX_RIGHT   = 3'd3,
		IDX_SIB     = 3'd4,
		IDX_PARENT  = 3'd5,
		IDX_RESTORE = 3'd6,
		IDX_INC     = 3'd7
	} idx_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_LN_RD,
		ST_LN_CHK,
		ST_LN_MUL,
		ST_LN_ADD,
		ST_LN_CMP,
		ST_LN_DEC,
		ST_LN_END,
		ST_SG_VISIT,
		ST_SG_RD,
		ST_SG_CHK,
		ST_SG_MUL,
		ST_SG_ADD,
		ST_SG_CMP,
		ST_SG_DEC,
		ST_SG_FIN,
		ST_Q_RD,
		ST_Q_CHK,
		ST_Q_MUL,
		ST_Q_ADD,
		ST_Q_ACC,
		ST_Q_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] slope;
		logic signed [31:0] intercept;
		logic signed [31:0] seg_lo;
		logic signed [31:0] seg_hi;
		logic signed [31:0] query_x;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] best_value;
		logic               found;
		logic               out_of_range;
	} out_item_t;

	// One stored tree node.
	typedef struct packed {
		logic               valid;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} node_t;

	typedef struct packed {
		logic    accept;
		logic    mem_wr;
		logic    clr;
		logic    swap;
		logic    load_na_seg;
		logic    save_idx;
		idx_op_t idx_op;
		pt_t     pt;
		logic    use_seg;
		logic    eval_mul;
		logic    eval_add;
		logic    eval_cmp;
		logic    acc_clear;
		logic    acc_upd;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       rd_valid;
		logic       leaf;
		logic       is_root;
		logic       idx_odd;
		logic       clr_last;
		logic       seg_empty;
		logic       seg_disjoint;
		logic       seg_cover;
		logic       qry_oor;
		logic       qry_left;
		logic [2:0] nw;
		logic [2:0] ob;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/lctlm_dp.sv
// ----------------------------------------------------------------------------
// lctlm_dp
// Datapath of the Li Chao tree: node store, node index and range logic,
// line evaluator with its comparators, query accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lctlm_dp
	import lctlm_pkg::*;
#(
	parameter int DOMAIN_BITS = DOMAIN_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [31:0] cfg_data,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output out_item_t  out_data
);

	localparam int IW    = DOMAIN_BITS + 1;
	localparam int LW    = $clog2(IW);
	localparam int NODES = 2 ** IW;

	// Configuration registers.
	logic signed [31:0] x_min_q;
	logic               mode_q;

	// Item registers and the line being pushed down.
	logic [1:0]         op_q;
	logic signed [31:0] ga_q, gb_q, na_q, nb_q;
	logic signed [31:0] sl_q, sr_q, qx_q;

	// Node index and the saved segment index.
	logic [IW-1:0] cur_q, save_q;

	node_t mem [NODES];
	node_t rd_q;
	node_t wdata;

	logic signed [63:0] prod_n_q, prod_s_q, val_n_q, val_s_q, acc_q;
	logic               have_q;
	logic [2:0]         nw_q, ob_q;
	out_item_t          out_q;
	out_item_t          out_n;

	logic [LW-1:0]      lvl;
	logic [LW-1:0]      sh;
	logic [IW-1:0]      size, lo, hi, mid, hi_m1, off_pt;
	logic signed [32:0] xmin_ext, xl, xlast, x_eval, sl_ext, sr_ext, qoff;
	logic signed [31:0] la, lb;
	logic signed [64:0] full_n, full_s;
	logic               oor;

	function automatic logic better(input logic signed [63:0] v,
	                                input logic signed [63:0] w,
	                                input logic m);
		return m ? (v > w) : (v < w);
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0;
			mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_MIN: x_min_q <= cfg_data;
				CFG_MODE:  mode_q  <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	// Node index register; it also serves as the address of the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else begin
			case (cmd.idx_op)
				IDX_ROOT:    cur_q <= IW'(1);
				IDX_LEFT:    cur_q <= {cur_q[IW-2:0], 1'b0};
				IDX_RIGHT:   cur_q <= {cur_q[IW-2:0], 1'b1};
				IDX_SIB:     cur_q <= {cur_q[IW-1:1], 1'b1};
				IDX_PARENT:  cur_q <= {1'b0, cur_q[IW-1:1]};
				IDX_RESTORE: cur_q <= save_q;
				IDX_INC:     cur_q <= cur_q + IW'(1);
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.save_idx) begin
			save_q <= cur_q;
		end
	end

	// Item capture and the line carried by the descent.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= in_data.operation;
			ga_q <= in_data.slope;
			gb_q <= in_data.intercept;
			na_q <= in_data.slope;
			nb_q <= in_data.intercept;
			sl_q <= in_data.seg_lo;
			sr_q <= in_data.seg_hi;
			qx_q <= in_data.query_x;
		end else if (cmd.load_na_seg) begin
			na_q <= ga_q;
			nb_q <= gb_q;
		end else if (cmd.swap) begin
			na_q <= rd_q.a;
			nb_q <= rd_q.b;
		end
	end

	// Node store: one write and one registered read, both at the node index.
	always_comb begin
		wdata = '0;
		if (!cmd.clr) begin
			wdata.valid = 1'b1;
			wdata.a     = na_q;
			wdata.b     = nb_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[cur_q] <= wdata;
		end
		rd_q <= mem[cur_q];
	end

	// Depth of the node and its offset range [lo, hi).
	always_comb begin
		lvl = '0;
		for (int i = 0; i < IW; i++) begin
			if (cur_q[i]) begin
				lvl = LW'(i);
			end
		end
		sh    = LW'(DOMAIN_BITS) - lvl;
		size  = IW'(1) << sh;
		lo    = (cur_q ^ (IW'(1) << lvl)) << sh;
		hi    = lo + size;
		mid   = lo + (size >> 1);
		hi_m1 = hi - IW'(1);
	end

	// Segment and query position tests.
	always_comb begin
		xmin_ext = {x_min_q[31], x_min_q};
		xl       = xmin_ext + $signed({{(33 - IW){1'b0}}, lo});
		xlast    = xmin_ext + $signed({{(33 - IW){1'b0}}, hi_m1});
		sl_ext   = {sl_q[31], sl_q};
		sr_ext   = {sr_q[31], sr_q};
		qoff     = $signed({qx_q[31], qx_q}) - xmin_ext;
		oor      = qoff[32] | (|qoff[31:DOMAIN_BITS]);
	end

	// Evaluation point and the two lines under comparison.
	always_comb begin
		case (cmd.pt)
			PT_LO:   off_pt = lo;
			PT_MID:  off_pt = mid;
			PT_HI:   off_pt = hi;
			default: off_pt = lo;
		endcase
		if (cmd.pt == PT_QRY) begin
			x_eval = {qx_q[31], qx_q};
		end else begin
			x_eval = xmin_ext + $signed({{(33 - IW){1'b0}}, off_pt});
		end
		la     = cmd.use_seg ? ga_q : na_q;
		lb     = cmd.use_seg ? gb_q : nb_q;
		full_n = la * x_eval;
		full_s = rd_q.a * x_eval;
	end

	// Evaluator: products, then sums, then the strict comparisons.
	always_ff @(posedge clk) begin
		if (cmd.eval_mul) begin
			prod_n_q <= full_n[63:0];
			prod_s_q <= full_s[63:0];
		end
		if (cmd.eval_add) begin
			val_n_q <= prod_n_q + {{32{lb[31]}}, lb};
			val_s_q <= prod_s_q + {{32{rd_q.b[31]}}, rd_q.b};
		end
		if (cmd.eval_cmp && cmd.pt != PT_QRY) begin
			nw_q[cmd.pt] <= better(val_n_q, val_s_q, mode_q);
			ob_q[cmd.pt] <= better(val_s_q, val_n_q, mode_q);
		end
	end

	// Query accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.acc_clear) begin
			have_q <= 1'b0;
		end else if (cmd.acc_upd) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_upd && (!have_q || better(val_s_q, acc_q, mode_q))) begin
			acc_q <= val_s_q;
		end
	end

	// Result of the finished item.
	always_comb begin
		out_n = '0;
		if (op_q == OP_QUERY) begin
			out_n.out_of_range = oor;
			if (!oor && have_q) begin
				out_n.best_value = acc_q;
				out_n.found      = 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= out_n;
		end
	end

	assign out_data = out_q;

	// Status towards the controller.
	always_comb begin
		status              = '0;
		status.op           = op_q;
		status.rd_valid     = rd_q.valid;
		status.leaf         = (lvl == LW'(DOMAIN_BITS));
		status.is_root      = (cur_q == IW'(1));
		status.idx_odd      = cur_q[0];
		status.clr_last     = &cur_q;
		status.seg_empty    = (sl_q > sr_q);
		status.seg_disjoint = (xlast < sl_ext) || (sr_ext < xl);
		status.seg_cover    = (sl_ext <= xl) && (xlast <= sr_ext);
		status.qry_oor      = oor;
		status.qry_left     = (qoff[IW-1:0] < mid);
		status.nw           = nw_q;
		status.ob           = ob_q;
	end

endmodule

`default_nettype wire

FILE: rtl/lctlm_ctrl.sv
// ----------------------------------------------------------------------------
// lctlm_ctrl
// Controller of the Li Chao tree: clearing sweep, line descent, segment
// traversal, query walk and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module lctlm_ctrl
	import lctlm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	pt_t    pt_q, pt_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pt_q        <= PT_LO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pt_q    <= pt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		pt_d    = pt_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (status.op)
					OP_ADD_ALL: state_d = ST_LN_RD;
					OP_ADD_SEG: state_d = status.seg_empty ? ST_DONE : ST_SG_VISIT;
					OP_QUERY:   state_d = status.qry_oor ? ST_DONE : ST_Q_RD;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_LN_RD: state_d = ST_LN_CHK;
			ST_LN_CHK: begin
				if (!status.rd_valid) begin
					state_d = ST_LN_END;
				end else begin
					pt_d    = PT_LO;
					state_d = ST_LN_MUL;
				end
			end
			ST_LN_MUL: state_d = ST_LN_ADD;
			ST_LN_ADD: state_d = ST_LN_CMP;
			ST_LN_CMP: begin
				if (status.leaf || pt_q == PT_HI) begin
					state_d = ST_LN_DEC;
				end else begin
					pt_d    = (pt_q == PT_LO) ? PT_MID : PT_HI;
					state_d = ST_LN_MUL;
				end
			end
			ST_LN_DEC: begin
				if (status.leaf || (status.nw[PT_LO] == status.nw[PT_HI])) begin
					state_d = ST_LN_END;
				end else begin
					state_d = ST_LN_RD;
				end
			end
			ST_LN_END: begin
				state_d = (status.op == OP_ADD_SEG) ? ST_SG_FIN : ST_DONE;
			end
			ST_SG_VISIT: begin
				if (status.seg_disjoint) begin
					state_d = ST_SG_FIN;
				end else if (status.seg_cover) begin
					state_d = ST_LN_RD;
				end else if (status.leaf) begin
					state_d = ST_SG_FIN;
				end else begin
					state_d = ST_SG_RD;
				end
			end
			ST_SG_RD: state_d = ST_SG_CHK;
			ST_SG_CHK: begin
				if (!status.rd_valid) begin
					state_d = ST_SG_VISIT;
				end else begin
					pt_d    = PT_LO;
					state_d = ST_SG_MUL;
				end
			end
			ST_SG_MUL: state_d = ST_SG_ADD;
			ST_SG_ADD: state_d = ST_SG_CMP;
			ST_SG_CMP: begin
				if (pt_q == PT_LO) begin
					pt_d    = PT_HI;
					state_d = ST_SG_MUL;
				end else begin
					state_d = ST_SG_DEC;
				end
			end
			ST_SG_DEC: begin
				state_d = (status.ob[PT_LO] && status.ob[PT_HI]) ? ST_SG_FIN : ST_SG_VISIT;
			end
			ST_SG_FIN: begin
				if (status.is_root) begin
					state_d = ST_DONE;
				end else if (!status.idx_odd) begin
					state_d = ST_SG_VISIT;
				end
			end
			ST_Q_RD: state_d = ST_Q_CHK;
			ST_Q_CHK: begin
				if (status.rd_valid) begin
					pt_d    = PT_QRY;
					state_d = ST_Q_MUL;
				end else begin
					state_d = ST_Q_NEXT;
				end
			end
			ST_Q_MUL: state_d = ST_Q_ADD;
			ST_Q_ADD: state_d = ST_Q_ACC;
			ST_Q_ACC: state_d = ST_Q_NEXT;
			ST_Q_NEXT: begin
				state_d = status.leaf ? ST_DONE : ST_Q_RD;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd        = '0;
		cmd.idx_op = IDX_HOLD;
		cmd.pt     = pt_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.mem_wr = 1'b1;
				cmd.clr    = 1'b1;
				cmd.idx_op = IDX_INC;
			end
			ST_IDLE: begin
				cmd.accept = in_valid;
			end
			ST_DISPATCH: begin
				cmd.acc_clear = 1'b1;
				case (status.op)
					OP_ADD_ALL: cmd.idx_op = IDX_ROOT;
					OP_ADD_SEG: cmd.idx_op = status.seg_empty ? IDX_HOLD : IDX_ROOT;
					OP_QUERY:   cmd.idx_op = status.qry_oor ? IDX_HOLD : IDX_ROOT;
					default:    cmd.idx_op = IDX_HOLD;
				endcase
			end
			ST_LN_CHK: begin
				cmd.mem_wr = !status.rd_valid;
			end
			ST_LN_MUL: cmd.eval_mul = 1'b1;
			ST_LN_ADD: cmd.eval_add = 1'b1;
			ST_LN_CMP: cmd.eval_cmp = 1'b1;
			ST_LN_DEC: begin
				// Leaf: only the left point decides.
				if (status.leaf) begin
					cmd.mem_wr = status.nw[PT_LO];
				end else if (status.nw[PT_LO] && status.nw[PT_HI]) begin
					cmd.mem_wr = 1'b1;
				end else if (status.nw[PT_LO] || status.nw[PT_HI]) begin
					// The lines cross inside: keep the mid-point winner here.
					cmd.mem_wr = status.nw[PT_MID];
					cmd.swap   = status.nw[PT_MID];
					cmd.idx_op = (status.nw[PT_LO] != status.nw[PT_MID]) ? IDX_LEFT : IDX_RIGHT;
				end
			end
			ST_LN_END: begin
				if (status.op == OP_ADD_SEG) begin
					cmd.idx_op = IDX_RESTORE;
				end
			end
			ST_SG_VISIT: begin
				if (!status.seg_disjoint && status.seg_cover) begin
					cmd.save_idx    = 1'b1;
					cmd.load_na_seg = 1'b1;
				end
			end
			ST_SG_CHK: begin
				if (!status.rd_valid) begin
					cmd.idx_op = IDX_LEFT;
				end
			end
			ST_SG_MUL: begin
				cmd.use_seg  = 1'b1;
				cmd.eval_mul = 1'b1;
			end
			ST_SG_ADD: begin
				cmd.use_seg  = 1'b1;
				cmd.eval_add = 1'b1;
			end
			ST_SG_CMP: begin
				cmd.use_seg  = 1'b1;
				cmd.eval_cmp = 1'b1;
			end
			ST_SG_DEC: begin
				if (!(status.ob[PT_LO] && status.ob[PT_HI])) begin
					cmd.idx_op = IDX_LEFT;
				end
			end
			ST_SG_FIN: begin
				if (!status.is_root) begin
					cmd.idx_op = status.idx_odd ? IDX_PARENT : IDX_SIB;
				end
			end
			ST_Q_MUL: cmd.eval_mul = 1'b1;
			ST_Q_ADD: cmd.eval_add = 1'b1;
			ST_Q_ACC: cmd.acc_upd  = 1'b1;
			ST_Q_NEXT: begin
				if (!status.leaf) begin
					cmd.idx_op = status.qry_left ? IDX_LEFT : IDX_RIGHT;
				end
			end
			ST_DONE: begin
				cmd.out_load = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/lichao_tree_line_min_max.sv
// ----------------------------------------------------------------------------
// lichao_tree_line_min_max
// Li Chao tree over x_min .. x_min + 2^DOMAIN_BITS - 1 that keeps the minimum
// or maximum of inserted lines, with whole-domain and segment inserts and
// point queries.
// ----------------------------------------------------------------------------
// One item is worked on at a time; each produces one result transfer. The
// cost is set by the single node store port and the shared line evaluator
// (multiply, add, compare for each point). A query visits one node per tree
// level; a whole-domain insert evaluates up to three points per level; a
// segment insert visits nodes of the tree, plus a descent for each covering
// node. After reset the node store is swept clear, one entry a cycle, over
// all 2^(DOMAIN_BITS+1) entries, during which no item is taken. A finished
// result waits in the output register while the next item is accepted.
`default_nettype none

module lichao_tree_line_min_max
	import lctlm_pkg::*;
#(
	parameter int DOMAIN_BITS = DOMAIN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencing of each operation.
	lctlm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Node store, evaluator and result register.
	lctlm_dp #(
		.DOMAIN_BITS (DOMAIN_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

FILE: test/lichao_tree_line_min_max_test.sv
// ----------------------------------------------------------------------------
// lichao_tree_line_min_max_test
// Self-checking testbench for the Li Chao tree block. Items are fed through a
// queue-driven sender with random bursts and gaps. A receiver stalls the
// result channel on a pattern of its own. Every accepted item is run through
// a behavioural tree model kept here, and each result transfer is checked,
// field by field, against the oldest prediction. The run steps through
// several x_min and mode settings, the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module lichao_tree_line_min_max_test
	import lctlm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DSIZE    = 1 << DOMAIN_BITS_DEF;
	localparam int NODES    = 2 << DOMAIN_BITS_DEF;
	localparam int IDLE_MAX = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_X_MIN;
	logic [31:0] cfg_data = '0;

	lichao_tree_line_min_max u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the tree and the configuration.
	bit      tree_ok [NODES];
	longint  tree_a  [NODES];
	longint  tree_b  [NODES];
	longint  shadow_xmin = 0;
	bit      shadow_mode = 1'b0;

	in_item_t  pending_items [$];
	out_item_t expected_results [$];

	int  fail_count = 0;
	int  results_seen = 0;
	int  queries_found = 0;
	int  queries_oor = 0;
	int  inserts_seen = 0;
	bit  in_taken = 1'b0;
	int  idle_cycles = 0;
	int  send_gap = 0;
	int  burst_left = 1;
	int  hold_left = 0;
	bit  did_hold = 1'b0;
	int  stall_pct = 30;

	function automatic bit better(longint v, longint w);
		return shadow_mode ? (v > w) : (v < w);
	endfunction

	function automatic bit new_beats(int idx, longint a, longint b, longint x);
		return better(a * x + b, tree_a[idx] * x + tree_b[idx]);
	endfunction

	function automatic void store_line(int idx, longint a, longint b);
		tree_ok[idx] = 1'b1;
		tree_a[idx]  = a;
		tree_b[idx]  = b;
	endfunction

	// Push a line down from a node, keeping the winner at each level.
	function automatic void push_line(int idx, longint a, longint b, int lo, int hi);
		int m;
		bit lw, mw, rw;
		longint oa, ob;
		while (idx < NODES) begin
			if (!tree_ok[idx]) begin
				store_line(idx, a, b);
				return;
			end
			if (hi == lo + 1) begin
				if (new_beats(idx, a, b, shadow_xmin + lo))
					store_line(idx, a, b);
				return;
			end
			m  = lo + (hi - lo) / 2;
			lw = new_beats(idx, a, b, shadow_xmin + lo);
			mw = new_beats(idx, a, b, shadow_xmin + m);
			rw = new_beats(idx, a, b, shadow_xmin + hi);
			if (lw && rw) begin
				store_line(idx, a, b);
				return;
			end
			if (!lw && !rw)
				return;
			if (mw) begin
				oa = tree_a[idx];
				ob = tree_b[idx];
				store_line(idx, a, b);
				a = oa;
				b = ob;
			end
			if (lw != mw) begin
				idx = 2 * idx;
				hi  = m;
			end else begin
				idx = 2 * idx + 1;
				lo  = m;
			end
		end
	endfunction

	// Split an inclusive segment over the nodes that it covers fully.
	function automatic void place_segment(int idx, longint a, longint b, int lo, int hi,
			longint sl, longint sr);
		longint xl, xlast, xr, sa, sb;
		int m;
		xl    = shadow_xmin + lo;
		xlast = shadow_xmin + hi - 1;
		xr    = shadow_xmin + hi;
		if (idx >= NODES || xlast < sl || sr < xl)
			return;
		if (sl <= xl && xlast <= sr) begin
			push_line(idx, a, b, lo, hi);
			return;
		end
		if (hi == lo + 1)
			return;
		if (tree_ok[idx] && !new_beats(idx, a, b, xl) && !new_beats(idx, a, b, xr)) begin
			sa = tree_a[idx];
			sb = tree_b[idx];
			if (better(sa * xl + sb, a * xl + b) && better(sa * xr + sb, a * xr + b))
				return;
		end
		m = lo + (hi - lo) / 2;
		place_segment(2 * idx, a, b, lo, m, sl, sr);
		place_segment(2 * idx + 1, a, b, m, hi, sl, sr);
	endfunction

	// Apply one item to the shadow tree and return the result it should give.
	function automatic out_item_t predict_result(in_item_t it);
		out_item_t r;
		longint off, v, acc;
		int idx, lo, hi, m;
		bit have;
		r = '0;
		case (op_t'(it.operation))
			OP_ADD_ALL: push_line(1, it.slope, it.intercept, 0, DSIZE);
			OP_ADD_SEG: begin
				if (it.seg_lo <= it.seg_hi)
					place_segment(1, it.slope, it.intercept, 0, DSIZE, it.seg_lo, it.seg_hi);
			end
			OP_QUERY: begin
				off = longint'(it.query_x) - shadow_xmin;
				if (off < 0 || off >= DSIZE) begin
					r.out_of_range = 1'b1;
				end else begin
					idx = 1; lo = 0; hi = DSIZE; acc = 0; have = 1'b0;
					while (idx < NODES) begin
						if (tree_ok[idx]) begin
							v = tree_a[idx] * longint'(it.query_x) + tree_b[idx];
							if (!have || better(v, acc))
								acc = v;
							have = 1'b1;
						end
						if (hi == lo + 1)
							break;
						m = lo + (hi - lo) / 2;
						if (off < m) begin
							idx = 2 * idx;
							hi  = m;
						end else begin
							idx = 2 * idx + 1;
							lo  = m;
						end
					end
					if (have) begin
						r.best_value = acc;
						r.found      = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Sample both channels, predict on each input transfer and check each result.
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && !in_stall;
			if (in_taken) begin
				expected_results.push_back(predict_result(in_data));
				if (op_t'(in_data.operation) inside {OP_ADD_ALL, OP_ADD_SEG})
					inserts_seen++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result transfer with no prediction waiting");
					fail_count++;
				end else begin
					automatic out_item_t want = expected_results.pop_front();
					if (out_data.best_value !== want.best_value) begin
						$error("best_value: expected %0d, got %0d", want.best_value,
							out_data.best_value);
						fail_count++;
					end
					if (out_data.found !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, out_data.found);
						fail_count++;
					end
					if (out_data.out_of_range !== want.out_of_range) begin
						$error("out_of_range: expected %0b, got %0b", want.out_of_range,
							out_data.out_of_range);
						fail_count++;
					end
					if (want.found) queries_found++;
					if (want.out_of_range) queries_oor++;
				end
			end
			// Watchdog on cycles with no transfer on either channel.
			if (in_taken || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_MAX) begin
					$display("lichao_tree_line_min_max: mismatch");
					$finish;
				end
			end
		end
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_data  <= pending_items.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls at a changing density, and one long hold-off.
	always @(negedge clk) begin
		if (!did_hold && results_seen >= 300) begin
			did_hold  = 1'b1;
			hold_left = 400;
		end
		if ($urandom_range(0, 63) == 0)
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	function automatic in_item_t line_item(op_t op, longint a, longint b, longint lo,
			longint hi, longint x);
		in_item_t it;
		it.operation = op;
		it.slope     = a[31:0];
		it.intercept = b[31:0];
		it.seg_lo    = lo[31:0];
		it.seg_hi    = hi[31:0];
		it.query_x   = x[31:0];
		return it;
	endfunction

	// Random item, mostly aimed inside the current domain.
	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		longint lo;
		it = line_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom);
		if ($urandom_range(0, 3) != 0) begin
			it.slope     = $signed($urandom_range(0, 2000)) - 1000;
			it.intercept = $signed($urandom_range(0, 2000000)) - 1000000;
		end
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			it.operation = OP_ADD_ALL;
		end else if (pick < 60) begin
			it.operation = OP_ADD_SEG;
			if ($urandom_range(0, 9) != 0) begin
				lo = shadow_xmin + $urandom_range(0, DSIZE + 100) - 50;
				it.seg_lo = lo[31:0];
				lo = lo + $urandom_range(0, 600) - 5;
				it.seg_hi = lo[31:0];
			end
		end else if (pick < 96) begin
			it.operation = OP_QUERY;
			if ($urandom_range(0, 9) != 0) begin
				lo = shadow_xmin + $urandom_range(0, DSIZE - 1);
				it.query_x = lo[31:0];
			end
		end else begin
			it.operation = OP_NONE;
		end
		return it;
	endfunction

	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_X_MIN)
			shadow_xmin = longint'($signed(value));
		else
			shadow_mode = value[0];
	endtask

	// Wait until the block has drained everything offered to it.
	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic run_phase(logic [31:0] xmin, bit mode_sel, int count);
		drain();
		write_reg(CFG_X_MIN, xmin);
		write_reg(CFG_MODE, {31'b0, mode_sel});
		repeat (count) pending_items.push_back(random_item());
	endtask

	localparam longint I32_MIN = -64'sd2147483648;
	localparam longint I32_MAX = 64'sd2147483647;

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items with the reset configuration written back explicitly.
		write_reg(CFG_X_MIN, 32'd0);
		write_reg(CFG_MODE, 32'd0);
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, 5));
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, -1));
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, DSIZE));
		pending_items.push_back(line_item(OP_NONE, -1, -1, -1, -1, -1));
		pending_items.push_back(line_item(OP_ADD_SEG, 3, 7, 500, 100, 0));
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, 300));
		pending_items.push_back(line_item(OP_ADD_SEG, 2, -40, -200, 100, 0));
		pending_items.push_back(line_item(OP_ADD_SEG, -1, 900, 900, 5000, 0));
		pending_items.push_back(line_item(OP_ADD_SEG, 0, 11, 333, 333, 0));
		pending_items.push_back(line_item(OP_ADD_ALL, I32_MAX, I32_MAX, 0, 0, 0));
		pending_items.push_back(line_item(OP_ADD_ALL, I32_MIN, I32_MIN, 0, 0, 0));
		pending_items.push_back(line_item(OP_ADD_ALL, 5, -10, 0, 0, 0));
		pending_items.push_back(line_item(OP_ADD_ALL, 5, -10, 0, 0, 0));
		pending_items.push_back(line_item(OP_ADD_SEG, -3, 100, I32_MIN, I32_MAX, 0));
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, 0));
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, 50));
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, 333));
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, 950));
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, DSIZE - 1));
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, I32_MIN));
		pending_items.push_back(line_item(OP_QUERY, 0, 0, 0, 0, I32_MAX));
		repeat (330) pending_items.push_back(random_item());

		// Further settings, the extremes of x_min and both modes among them.
		run_phase(32'h8000_0000, 1'b1, 350);
		run_phase(32'h7fff_fc00, 1'b0, 350);
		run_phase(32'h7fff_ffff, 1'b1, 100);
		run_phase(-32'sd300, 1'b1, 300);
		run_phase($urandom, 1'b0, 300);
		drain();

		repeat (200) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d predicted results never arrived", expected_results.size());
			fail_count++;
		end
		$display("Checked %0d results: %0d inserts, %0d queries with a line found,",
			results_seen, inserts_seen, queries_found);
		$display("%0d queries outside the domain, over six x_min and mode settings.",
			queries_oor);
		if (fail_count == 0)
			$display("lichao_tree_line_min_max: match");
		else
			$display("lichao_tree_line_min_max: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

FILE: lichao_tree_line_min_max.f
rtl/lctlm_pkg.sv
rtl/lctlm_dp.sv
rtl/lctlm_ctrl.sv
rtl/lichao_tree_line_min_max.sv
test/lichao_tree_line_min_max_test.sv
